/* rtl/sfse_pkg.sv */
// Shared types and constants for the set-family star excess checker.
// No dependencies.
package sfse_pkg;

   localparam int MASK_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int GROUND_W = 4;
   localparam int FAMILY_W = 9;
   localparam int DEGREE_W = 8;
   localparam int EXCESS_W = 10;
   localparam int ELIGIBLE_MIN = 3;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_DRAIN,
      ST_PEAK,
      ST_DONE
   } state_type;

   // stored generator handed from one cell to the next on a load
   typedef struct packed {
      logic              valid;
      logic [MASK_W-1:0] mask;
      logic              fail;
   } slot_type;

   // broadcast load control
   typedef struct packed {
      logic              load;
      logic              clear;
      logic [MASK_W-1:0] mask;
   } load_type;

   // evaluation token swept through the chain
   typedef struct packed {
      logic              vld;
      logic              lst;
      logic [MASK_W-1:0] t;
      logic              in_cl;
      logic              hit;
      logic              fail;
   } token_type;

endpackage

/* rtl/sfse_if.sv */
// Valid/ready channel interfaces for the set-family star excess checker.
// Depends on sfse_pkg.
interface sfse_req_if;
   logic                       valid;
   logic                       ready;
   logic [sfse_pkg::MASK_W-1:0] generator_mask;
   logic                       last;
   modport source (output valid, generator_mask, last, input ready);
   modport sink   (input valid, generator_mask, last, output ready);
endinterface

interface sfse_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfse_pkg::FAMILY_W-1:0] family_size;
   logic [sfse_pkg::DEGREE_W-1:0] max_degree;
   logic signed [sfse_pkg::EXCESS_W-1:0] excess;
   logic [sfse_pkg::COUNT_W-1:0]  generator_total;
   logic                          pairwise_ok;
   logic                          eligible;
   logic                          violation;
   modport source (output valid, family_size, max_degree, excess, generator_total,
                   pairwise_ok, eligible, violation, input ready);
   modport sink   (input valid, family_size, max_degree, excess, generator_total,
                   pairwise_ok, eligible, violation, output ready);
endinterface

/* rtl/set_family_star_excess_check.sv */
// Top level of the set-family star excess checker.
// Depends on sfse_pkg, sfse_if and sfse_cell.
//
// Generators arrive one per transaction on req_chan: the new mask enters the head of a row
// of MAX_GENERATORS cells and every stored mask moves one cell along, while each cell
// checks the arrival against its own mask for the pairwise test. A transaction marked
// last starts the evaluation: all 2**MAX_GROUND masks are swept through the row, one per
// cycle, each picking up whether it lies under a stored generator (so belongs to the
// down-closure) and whether it contains one, then the element degrees are scanned one
// element a cycle. The result waits in an output register, and further generators are
// taken while it waits; a new result is held back until the old one has gone. Ground
// size is written over csr_we/csr_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module set_family_star_excess_check #(
   parameter int MAX_GENERATORS = 128,
   parameter int MAX_GROUND     = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sfse_pkg::GROUND_W-1:0] csr_wdata,
   sfse_req_if.sink                      req_chan,
   sfse_rsp_if.source                    rsp_chan
);
   import sfse_pkg::*;

   localparam int X_W        = $clog2(MAX_GROUND);

   state_type state_ff, state_in;

   logic [GROUND_W-1:0]   ground_ff;
   logic [GROUND_W-1:0]   ng;
   logic [MASK_W-1:0]     gmask;
   logic [MASK_W-1:0]     s;
   logic                  accept, full, do_load, do_clear;

   logic [COUNT_W-1:0]    count_ff;
   logic [MASK_W-1:0]     and_ff, or_ff;
   logic [MAX_GROUND-1:0] sweep_ff;
   logic [X_W-1:0]        x_ff;
   logic [FAMILY_W-1:0]   family_ff;
   logic [FAMILY_W-1:0]   deg_ff [MAX_GROUND];
   logic [FAMILY_W-1:0]   peak_ff;
   logic                  fail_ff;

   load_type  ctl;
   slot_type  slots [MAX_GENERATORS+1];
   token_type toks  [MAX_GENERATORS+1];
   token_type exit_tok;

   logic                  rsp_valid_ff;
   logic [FAMILY_W-1:0]   r_family_ff;
   logic [DEGREE_W-1:0]   r_degree_ff;
   logic [EXCESS_W-1:0]   r_excess_ff;
   logic [COUNT_W-1:0]    r_total_ff;
   logic                  r_pair_ff, r_elig_ff, r_viol_ff;
   logic [EXCESS_W-1:0]   excess;
   logic                  eligible;

   // clamp ground size and build the ground mask
   always_comb begin
      ng = ground_ff;
      if (ground_ff == '0) ng = GROUND_W'(1);
      if (ground_ff > GROUND_W'(MAX_GROUND)) ng = GROUND_W'(MAX_GROUND);
      for (int b = 0; b < MASK_W; b++) gmask[b] = (GROUND_W'(b) < ng);
   end

   assign s        = req_chan.generator_mask & gmask;
   assign full     = (count_ff == COUNT_W'(MAX_GENERATORS));
   assign accept   = req_chan.valid && req_chan.ready;
   assign do_load  = accept && !full;
   assign do_clear = (state_ff == ST_DONE) && !rsp_valid_ff;
   assign req_chan.ready = (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) ground_ff <= GROUND_W'(8);
      else if (csr_we) ground_ff <= csr_wdata;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  if (accept && req_chan.last) state_in = ST_SWEEP;
         ST_SWEEP: if (sweep_ff == '1) state_in = ST_DRAIN;
         ST_DRAIN: if (exit_tok.vld && exit_tok.lst) state_in = ST_PEAK;
         ST_PEAK:  if (x_ff == X_W'(MAX_GROUND - 1)) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else state_ff <= state_in;
   end

   // cell row: new mask enters at the head, stored masks advance one cell
   assign ctl.load  = do_load;
   assign ctl.clear = do_clear;
   assign ctl.mask  = s;
   assign slots[0].valid = 1'b1;
   assign slots[0].mask  = s;
   assign slots[0].fail  = 1'b0;

   always_comb begin
      toks[0].vld   = (state_ff == ST_SWEEP);
      toks[0].lst   = (sweep_ff == '1);
      toks[0].t     = MASK_W'(sweep_ff);
      toks[0].in_cl = 1'b0;
      toks[0].hit   = 1'b0;
      toks[0].fail  = 1'b0;
   end

   for (genvar i = 0; i < MAX_GENERATORS; i++) begin : g_cell
      sfse_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .slot_left  (slots[i]),
         .slot_right (slots[i+1]),
         .tok_left   (toks[i]),
         .tok_right  (toks[i+1])
      );
   end

   assign exit_tok = toks[MAX_GENERATORS];

   // running masks and count
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         count_ff   <= '0;
         and_ff     <= '1;
         or_ff      <= '0;
      end else if (do_load) begin
         count_ff <= count_ff + COUNT_W'(1);
         and_ff   <= and_ff & s;
         or_ff    <= or_ff | s;
      end
   end

   // sweep counter and element scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         x_ff     <= '0;
      end else begin
         if (state_ff == ST_SWEEP) sweep_ff <= sweep_ff + MAX_GROUND'(1);
         else sweep_ff <= '0;
         if (state_ff == ST_PEAK) x_ff <= x_ff + X_W'(1);
         else x_ff <= '0;
      end
   end

   // tally tokens leaving the row, then find the peak degree
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         family_ff <= '0;
         peak_ff   <= '0;
         fail_ff   <= 1'b0;
         for (int x = 0; x < MAX_GROUND; x++) deg_ff[x] <= '0;
      end else begin
         if (exit_tok.vld) begin
            fail_ff <= fail_ff | exit_tok.fail;
            if (exit_tok.in_cl) begin
               if (exit_tok.hit) family_ff <= family_ff + FAMILY_W'(1);
               for (int x = 0; x < MAX_GROUND; x++)
                  if (GROUND_W'(x) < ng && exit_tok.t[x])
                     deg_ff[x] <= deg_ff[x] + FAMILY_W'(1);
            end
         end
         if (state_ff == ST_PEAK && GROUND_W'(x_ff) < ng && deg_ff[x_ff] > peak_ff)
            peak_ff <= deg_ff[x_ff];
      end
   end

   // result
   assign excess   = EXCESS_W'(family_ff) - EXCESS_W'(peak_ff);
   assign eligible = (count_ff >= COUNT_W'(ELIGIBLE_MIN)) && (and_ff == '0) &&
                     (or_ff == gmask);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (do_clear) rsp_valid_ff <= 1'b1;
      else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      if (do_clear) begin
         r_family_ff <= family_ff;
         r_degree_ff <= DEGREE_W'(peak_ff);
         r_excess_ff <= excess;
         r_total_ff  <= count_ff;
         r_pair_ff   <= !fail_ff;
         r_elig_ff   <= eligible;
         r_viol_ff   <= eligible && !excess[EXCESS_W-1] && (excess != '0);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.family_size     = r_family_ff;
   assign rsp_chan.max_degree      = r_degree_ff;
   assign rsp_chan.excess          = r_excess_ff;
   assign rsp_chan.generator_total = r_total_ff;
   assign rsp_chan.pairwise_ok     = r_pair_ff;
   assign rsp_chan.eligible        = r_elig_ff;
   assign rsp_chan.violation       = r_viol_ff;

endmodule

/* rtl/sfse_cell.sv */
// One generator cell: holds a mask, checks arrivals against it and marks sweep tokens.
// Depends on sfse_pkg.
module sfse_cell (
   input  logic                clock,
   input  logic                reset,
   input  sfse_pkg::load_type  ctl,
   input  sfse_pkg::slot_type  slot_left,
   output sfse_pkg::slot_type  slot_right,
   input  sfse_pkg::token_type tok_left,
   output sfse_pkg::token_type tok_right
);
   import sfse_pkg::*;

   logic              valid_ff, valid_in;
   logic              fail_ff, fail_in;
   logic [MASK_W-1:0] mask_ff;
   token_type         tok_ff, tok_in;
   logic [MASK_W-1:0] meet;
   logic              clash;

   always_comb begin
      meet  = mask_ff & ctl.mask;
      clash = valid_ff && (meet == '0 || meet == ctl.mask || meet == mask_ff);
      slot_right.valid = valid_ff;
      slot_right.mask  = mask_ff;
      slot_right.fail  = fail_ff | clash;
      valid_in = valid_ff;
      fail_in  = fail_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
         fail_in  = 1'b0;
      end else if (ctl.load) begin
         valid_in = slot_left.valid;
         fail_in  = slot_left.fail;
      end
      tok_in       = tok_left;
      // mark the token as lying under this mask (down-closure) or holding it
      tok_in.in_cl = tok_left.in_cl | (valid_ff && ((tok_left.t & ~mask_ff) == '0));
      tok_in.hit   = tok_left.hit | (valid_ff && ((tok_left.t & mask_ff) == mask_ff));
      tok_in.fail  = tok_left.fail | fail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         fail_ff    <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         fail_ff    <= fail_in;
         tok_ff.vld <= tok_in.vld;
      end
      if (ctl.load) mask_ff <= slot_left.mask;
      tok_ff.lst   <= tok_in.lst;
      tok_ff.t     <= tok_in.t;
      tok_ff.in_cl <= tok_in.in_cl;
      tok_ff.hit   <= tok_in.hit;
      tok_ff.fail  <= tok_in.fail;
   end

   assign tok_right = tok_ff;

endmodule
